// File: hw/rtl/sfn_pkg.sv
// ----------------------------------------------------------------------------
// sfn_pkg: shared types and constants of the spatial focus navigator
// State encoding, request codes, field widths and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sfn_pkg;

    // Request codes carried on s_tuser.
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_BUILD  = 2'd2,
        REQ_MOVE   = 2'd3
    } sfn_req_t;

    // Move directions; also the slot order inside a neighbor row.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;
    localparam int         NUM_DIRS  = 4;

    // Input field widths.
    localparam int POS_W  = 15;
    localparam int SIZE_W = 12;
    localparam int DIR_W  = 2;
    localparam int REQ_W  = 2;

    // Doubled center, center delta, its magnitude and the squared distance.
    localparam int CX_W   = 18;
    localparam int DELTA_W = 19;
    localparam int ABS_W  = 17;
    localparam int SQ_W   = 34;
    localparam int DIST_W = 35;

    // Result field widths and packed stream widths.
    localparam int FOCUS_W   = 5;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOVE_AP,
        ST_B_SREAD,
        ST_B_SLOAD,
        ST_B_ISSUE,
        ST_B_DRAIN,
        ST_B_WRITE,
        ST_RESP
    } sfn_state_t;

    typedef struct packed {
        logic latch_req;
        logic do_clear;
        logic do_append;
        logic build_empty;
        logic build_done;
        logic move_rd;
        logic move_apply;
        logic s_init;
        logic s_read;
        logic s_load;
        logic s_next;
        logic t_issue;
        logic row_write;
        logic resp_load;
    } sfn_cmd_t;

    typedef struct packed {
        sfn_req_t req_type;
        logic     count_zero;
        logic     t_last;
        logic     s_last;
        logic     pipe_busy;
    } sfn_stat_t;

    typedef struct packed {
        logic               table_full;
        logic               focus_changed;
        logic               focus_valid;
        logic [FOCUS_W-1:0] focus_index;
    } sfn_result_t;

endpackage

// File: hw/rtl/sfn_ctrl.sv
// ----------------------------------------------------------------------------
// sfn_ctrl: request sequencer
// Accepts one request at a time, steps the datapath through clear, append,
// move and the element-by-element neighbor build, then hands off the result.
// ----------------------------------------------------------------------------
module sfn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_fire,
    input  logic              out_free,
    input  sfn_pkg::sfn_stat_t stat,
    output logic              req_ready,
    output sfn_pkg::sfn_cmd_t  cmd
);

    sfn_pkg::sfn_state_t state_reg;
    sfn_pkg::sfn_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfn_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            sfn_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_fire) begin
                    cmd.latch_req = 1'b1;
                    state_next    = sfn_pkg::ST_EXEC;
                end
            end
            sfn_pkg::ST_EXEC: begin
                unique case (stat.req_type)
                    sfn_pkg::REQ_CLEAR: begin
                        cmd.do_clear = 1'b1;
                        state_next   = sfn_pkg::ST_RESP;
                    end
                    sfn_pkg::REQ_APPEND: begin
                        cmd.do_append = 1'b1;
                        state_next    = sfn_pkg::ST_RESP;
                    end
                    sfn_pkg::REQ_BUILD: begin
                        if (stat.count_zero) begin
                            cmd.build_empty = 1'b1;
                            state_next      = sfn_pkg::ST_RESP;
                        end else begin
                            cmd.s_init = 1'b1;
                            state_next = sfn_pkg::ST_B_SREAD;
                        end
                    end
                    sfn_pkg::REQ_MOVE: begin
                        cmd.move_rd = 1'b1;
                        state_next  = sfn_pkg::ST_MOVE_AP;
                    end
                    default: begin
                        state_next = sfn_pkg::ST_RESP;
                    end
                endcase
            end
            sfn_pkg::ST_MOVE_AP: begin
                cmd.move_apply = 1'b1;
                state_next     = sfn_pkg::ST_RESP;
            end
            sfn_pkg::ST_B_SREAD: begin
                cmd.s_read = 1'b1;
                state_next = sfn_pkg::ST_B_SLOAD;
            end
            sfn_pkg::ST_B_SLOAD: begin
                cmd.s_load = 1'b1;
                state_next = sfn_pkg::ST_B_ISSUE;
            end
            sfn_pkg::ST_B_ISSUE: begin
                cmd.t_issue = 1'b1;
                if (stat.t_last) begin
                    state_next = sfn_pkg::ST_B_DRAIN;
                end
            end
            sfn_pkg::ST_B_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = sfn_pkg::ST_B_WRITE;
                end
            end
            sfn_pkg::ST_B_WRITE: begin
                cmd.row_write = 1'b1;
                if (stat.s_last) begin
                    cmd.build_done = 1'b1;
                    state_next     = sfn_pkg::ST_RESP;
                end else begin
                    cmd.s_next = 1'b1;
                    state_next = sfn_pkg::ST_B_SREAD;
                end
            end
            sfn_pkg::ST_RESP: begin
                if (out_free) begin
                    cmd.resp_load = 1'b1;
                    state_next    = sfn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sfn_datapath.sv
// ----------------------------------------------------------------------------
// sfn_datapath: element table, distance pipeline and focus state
// Holds the doubled-center memories, the neighbor row memory, the element
// count and the focus, and runs one source/target pair per cycle through a
// three-stage delta, square and compare pipeline during a build.
// ----------------------------------------------------------------------------
module sfn_datapath #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sfn_pkg::sfn_cmd_t              cmd,
    input  logic [sfn_pkg::REQ_W-1:0]      in_req_type,
    input  logic [sfn_pkg::POS_W-1:0]      in_pos_x,
    input  logic [sfn_pkg::POS_W-1:0]      in_pos_y,
    input  logic [sfn_pkg::SIZE_W-1:0]     in_width,
    input  logic [sfn_pkg::SIZE_W-1:0]     in_height,
    input  logic [sfn_pkg::DIR_W-1:0]      in_move_direction,
    output sfn_pkg::sfn_stat_t             stat,
    output sfn_pkg::sfn_result_t           result
);

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int LINK_W = IDX_W + 1;
    localparam int ROW_W  = sfn_pkg::NUM_DIRS * LINK_W;

    // Latched request.
    logic [sfn_pkg::REQ_W-1:0]  req_type_reg;
    logic [sfn_pkg::POS_W-1:0]  pos_x_reg;
    logic [sfn_pkg::POS_W-1:0]  pos_y_reg;
    logic [sfn_pkg::SIZE_W-1:0] width_reg;
    logic [sfn_pkg::SIZE_W-1:0] height_reg;
    logic [sfn_pkg::DIR_W-1:0]  dir_reg;

    // Table state.
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] focus_idx_reg;
    logic             focus_vld_reg;
    logic             changed_reg;
    logic             full_reg;

    // Memories.
    logic [sfn_pkg::CX_W-1:0] cx_mem [MAX_ELEMENTS];
    logic [sfn_pkg::CX_W-1:0] cy_mem [MAX_ELEMENTS];
    logic [ROW_W-1:0]         link_mem [MAX_ELEMENTS];
    logic [sfn_pkg::CX_W-1:0] rd_x_reg;
    logic [sfn_pkg::CX_W-1:0] rd_y_reg;
    logic [ROW_W-1:0]         link_rd_reg;

    // Build loop.
    logic [IDX_W-1:0]         s_reg;
    logic [IDX_W-1:0]         t_reg;
    logic [sfn_pkg::CX_W-1:0] cs_x_reg;
    logic [sfn_pkg::CX_W-1:0] cs_y_reg;

    // Pipeline.
    logic                          p1_valid_reg;
    logic [IDX_W-1:0]              p1_t_reg;
    logic                          p2_valid_reg;
    logic [IDX_W-1:0]              p2_t_reg;
    logic [1:0]                    p2_dir_reg;
    logic [sfn_pkg::ABS_W-1:0]     p2_ax_reg;
    logic [sfn_pkg::ABS_W-1:0]     p2_ay_reg;
    logic                          p3_valid_reg;
    logic [IDX_W-1:0]              p3_t_reg;
    logic [1:0]                    p3_dir_reg;
    logic [sfn_pkg::SQ_W-1:0]      p3_sqx_reg;
    logic [sfn_pkg::SQ_W-1:0]      p3_sqy_reg;

    logic [sfn_pkg::DIST_W-1:0] best_dist_reg [sfn_pkg::NUM_DIRS];
    logic [IDX_W-1:0]           best_idx_reg  [sfn_pkg::NUM_DIRS];
    logic                       best_vld_reg  [sfn_pkg::NUM_DIRS];

    // Combinational helpers.
    logic [sfn_pkg::CX_W-1:0]    new_cx;
    logic [sfn_pkg::CX_W-1:0]    new_cy;
    logic                        table_full_now;
    logic [IDX_W-1:0]            rd_addr;
    logic [CNT_W-1:0]            count_m1;
    logic [IDX_W-1:0]            last_idx;
    logic [sfn_pkg::DELTA_W-1:0] dx;
    logic [sfn_pkg::DELTA_W-1:0] dy;
    logic [sfn_pkg::DELTA_W-1:0] adx;
    logic [sfn_pkg::DELTA_W-1:0] ady;
    logic [sfn_pkg::ABS_W-1:0]   ax;
    logic [sfn_pkg::ABS_W-1:0]   ay;
    logic [1:0]                  dir_now;
    logic [sfn_pkg::DIST_W-1:0]  dist_now;
    logic                        take_now;
    logic [ROW_W-1:0]            row_data;
    logic [LINK_W-1:0]           move_link;
    logic [sfn_pkg::FOCUS_W+IDX_W-1:0] focus_ext;

    // Doubled center: 2*pos + size, sign-extended to the center width.
    assign new_cx = {{2{pos_x_reg[sfn_pkg::POS_W-1]}}, pos_x_reg, 1'b0}
                  + {{(sfn_pkg::CX_W - sfn_pkg::SIZE_W){1'b0}}, width_reg};
    assign new_cy = {{2{pos_y_reg[sfn_pkg::POS_W-1]}}, pos_y_reg, 1'b0}
                  + {{(sfn_pkg::CX_W - sfn_pkg::SIZE_W){1'b0}}, height_reg};

    assign table_full_now = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign rd_addr        = cmd.s_read ? s_reg : t_reg;
    assign count_m1       = count_reg - CNT_W'(1);
    assign last_idx       = count_m1[IDX_W-1:0];

    // Stage one: center delta, magnitudes and dominant-axis direction.
    assign dx  = {rd_x_reg[sfn_pkg::CX_W-1], rd_x_reg} - {cs_x_reg[sfn_pkg::CX_W-1], cs_x_reg};
    assign dy  = {rd_y_reg[sfn_pkg::CX_W-1], rd_y_reg} - {cs_y_reg[sfn_pkg::CX_W-1], cs_y_reg};
    assign adx = dx[sfn_pkg::DELTA_W-1] ? (~dx + sfn_pkg::DELTA_W'(1)) : dx;
    assign ady = dy[sfn_pkg::DELTA_W-1] ? (~dy + sfn_pkg::DELTA_W'(1)) : dy;
    assign ax  = adx[sfn_pkg::ABS_W-1:0];
    assign ay  = ady[sfn_pkg::ABS_W-1:0];

    always_comb begin
        if (ax > ay) begin
            dir_now = dx[sfn_pkg::DELTA_W-1] ? sfn_pkg::DIR_LEFT : sfn_pkg::DIR_RIGHT;
        end else if (!dy[sfn_pkg::DELTA_W-1] && (dy != '0)) begin
            dir_now = sfn_pkg::DIR_DOWN;
        end else begin
            // A zero delta falls here and counts as up.
            dir_now = sfn_pkg::DIR_UP;
        end
    end

    // Stage three: strict compare keeps the earlier target on a tie.
    assign dist_now = {1'b0, p3_sqx_reg} + {1'b0, p3_sqy_reg};
    assign take_now = p3_valid_reg &&
                      (!best_vld_reg[p3_dir_reg] || (dist_now < best_dist_reg[p3_dir_reg]));

    always_comb begin
        for (int d = 0; d < sfn_pkg::NUM_DIRS; d++) begin
            row_data[d*LINK_W +: LINK_W] = {best_vld_reg[d], best_idx_reg[d]};
        end
    end

    assign move_link = link_rd_reg[dir_reg*LINK_W +: LINK_W];

    // Memories. A neighbor row is only read at the focus, and the focus is
    // valid only after a build has rewritten every row up to the count.
    always_ff @(posedge aclk) begin
        if (cmd.do_append && !table_full_now) begin
            cx_mem[count_reg[IDX_W-1:0]] <= new_cx;
            cy_mem[count_reg[IDX_W-1:0]] <= new_cy;
        end
        rd_x_reg <= cx_mem[rd_addr];
        rd_y_reg <= cy_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_write) begin
            link_mem[s_reg] <= row_data;
        end
        if (cmd.move_rd) begin
            link_rd_reg <= link_mem[focus_idx_reg];
        end
    end

    // Request latch and payload pipeline registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_type_reg <= in_req_type;
            pos_x_reg    <= in_pos_x;
            pos_y_reg    <= in_pos_y;
            width_reg    <= in_width;
            height_reg   <= in_height;
            dir_reg      <= in_move_direction;
        end
        if (cmd.s_load) begin
            cs_x_reg <= rd_x_reg;
            cs_y_reg <= rd_y_reg;
        end
        p1_t_reg   <= t_reg;
        p2_t_reg   <= p1_t_reg;
        p2_dir_reg <= dir_now;
        p2_ax_reg  <= ax;
        p2_ay_reg  <= ay;
        p3_t_reg   <= p2_t_reg;
        p3_dir_reg <= p2_dir_reg;
        p3_sqx_reg <= p2_ax_reg * p2_ax_reg;
        p3_sqy_reg <= p2_ay_reg * p2_ay_reg;
        for (int d = 0; d < sfn_pkg::NUM_DIRS; d++) begin
            if (take_now && (p3_dir_reg == 2'(d))) begin
                best_dist_reg[d] <= dist_now;
                best_idx_reg[d]  <= p3_t_reg;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            focus_idx_reg <= '0;
            focus_vld_reg <= 1'b0;
            changed_reg   <= 1'b0;
            full_reg      <= 1'b0;
            s_reg         <= '0;
            t_reg         <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            for (int d = 0; d < sfn_pkg::NUM_DIRS; d++) begin
                best_vld_reg[d] <= 1'b0;
            end
        end else begin
            if (cmd.latch_req) begin
                changed_reg <= 1'b0;
                full_reg    <= 1'b0;
            end
            if (cmd.do_clear) begin
                count_reg     <= '0;
                focus_idx_reg <= '0;
                focus_vld_reg <= 1'b0;
            end
            if (cmd.do_append) begin
                if (table_full_now) begin
                    full_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.build_empty) begin
                focus_idx_reg <= '0;
                focus_vld_reg <= 1'b0;
            end
            if (cmd.build_done) begin
                focus_idx_reg <= '0;
                focus_vld_reg <= 1'b1;
                changed_reg   <= 1'b1;
            end
            if (cmd.move_apply && focus_vld_reg && move_link[LINK_W-1]) begin
                focus_idx_reg <= move_link[IDX_W-1:0];
                changed_reg   <= 1'b1;
            end
            if (cmd.s_init) begin
                s_reg <= '0;
            end else if (cmd.s_next) begin
                s_reg <= s_reg + IDX_W'(1);
            end
            if (cmd.s_load) begin
                t_reg <= '0;
            end else if (cmd.t_issue) begin
                t_reg <= t_reg + IDX_W'(1);
            end
            p1_valid_reg <= cmd.t_issue && (t_reg != s_reg);
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            for (int d = 0; d < sfn_pkg::NUM_DIRS; d++) begin
                if (cmd.s_load) begin
                    best_vld_reg[d] <= 1'b0;
                end else if (take_now && (p3_dir_reg == 2'(d))) begin
                    best_vld_reg[d] <= 1'b1;
                end
            end
        end
    end

    assign stat.req_type   = sfn_pkg::sfn_req_t'(req_type_reg);
    assign stat.count_zero = (count_reg == '0);
    assign stat.t_last     = (t_reg == last_idx);
    assign stat.s_last     = (s_reg == last_idx);
    assign stat.pipe_busy  = p1_valid_reg || p2_valid_reg || p3_valid_reg;

    assign focus_ext            = {{sfn_pkg::FOCUS_W{1'b0}}, focus_idx_reg};
    assign result.focus_index   = focus_vld_reg ? focus_ext[sfn_pkg::FOCUS_W-1:0] : '0;
    assign result.focus_valid   = focus_vld_reg;
    assign result.focus_changed = changed_reg;
    assign result.table_full    = full_reg;

endmodule

// File: hw/rtl/spatial_focus_navigator.sv
// ----------------------------------------------------------------------------
// spatial_focus_navigator: four-way focus navigation over a rectangle table
// Top level: stream ports, controller, datapath and the result register.
// ----------------------------------------------------------------------------
// One request word is taken at a time and each gives exactly one result word.
// Clear and append go from the request latch straight to the result; a move
// takes one state more, since the neighbor row is read from memory first.
// A build runs, for each source element, one center read, one load, one
// target issue per element at one pair per cycle through the three-stage
// distance pipeline (the pair of a source with itself is skipped), a drain
// of the pipeline and one neighbor row write. Each result waits until the
// output register is free. The next request is accepted as soon as the
// result is in the output register, even while that result still waits on
// m_tready.
module spatial_focus_navigator #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[14:0], pos_y[29:15], width[41:30], height[53:42],
    // move_direction[55:54]
    input  logic [sfn_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [sfn_pkg::REQ_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // focus_index[4:0], focus_valid[5], focus_changed[6], table_full[7]
    output logic [sfn_pkg::M_TDATA_W-1:0]   m_tdata
);

    sfn_pkg::sfn_cmd_t    cmd;
    sfn_pkg::sfn_stat_t   stat;
    sfn_pkg::sfn_result_t result;

    logic                          out_valid_reg;
    logic [sfn_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                          out_free;
    logic                          req_ready;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = req_ready;

    sfn_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_fire  (s_tvalid && req_ready),
        .out_free  (out_free),
        .stat      (stat),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    sfn_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_req_type       (s_tuser),
        .in_pos_x          (s_tdata[14:0]),
        .in_pos_y          (s_tdata[29:15]),
        .in_width          (s_tdata[41:30]),
        .in_height         (s_tdata[53:42]),
        .in_move_direction (s_tdata[55:54]),
        .stat              (stat),
        .result            (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.resp_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.resp_load) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hw/rtl/sfn_checker.sv
// ----------------------------------------------------------------------------
// sfn_checker: port-level checks for the spatial focus navigator
// Watches the stream ports and flags result words that break the block's
// rules; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module sfn_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sfn_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Requests are handled one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Without focus the index reads zero and nothing can have changed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[5] |-> (m_tdata[4:0] == '0) && !m_tdata[6])
        else $error("focus index or change flag set without focus");

    // A dropped append never moves the focus.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> !m_tdata[6])
        else $error("table full and focus change in one word");

endmodule

bind spatial_focus_navigator sfn_checker u_sfn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the spatial focus navigator
// A directed opening and then random element tables go through the block:
// clears, appends, neighbor builds and moves. A model of the table, the
// neighbor links and the focus predicts each result word, and the words that
// come out are checked against it in order. The sender and the receiver idle
// at random by phase: neither in the first of four, then the sender, then the receiver, then both.
// ----------------------------------------------------------------------------
module tb_top;
    import sfn_pkg::*;

    localparam int MAXE         = 32;
    localparam int NUM_ITEMS    = 580;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int QUIET_CYCLES = 40;

    // Field offsets inside s_tdata.
    localparam int PY_LSB  = POS_W;
    localparam int W_LSB   = 2 * POS_W;
    localparam int H_LSB   = 2 * POS_W + SIZE_W;
    localparam int DIR_LSB = 2 * POS_W + 2 * SIZE_W;

    typedef struct {
        sfn_req_t           req;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [DIR_W-1:0]   dir;
        bit                 drain_first;
        int                 phase;
    } req_word_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [REQ_W-1:0]       s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    req_word_t   pending_q[$];
    sfn_result_t expected_focus_q[$];

    int send_idle_pct[4] = '{0, 83, 0, 17};
    int recv_stall_pct[4] = '{0, 0, 83, 17};

    // Model of the table, the links and the focus.
    int elem_cx[MAXE];
    int elem_cy[MAXE];
    int nb_idx[MAXE][NUM_DIRS];
    bit nb_ok[MAXE][NUM_DIRS];
    int elem_count = 0;
    int focus_idx  = 0;
    bit focus_ok   = 1'b0;

    int gen_count  = 0;
    int gen_phase  = 0;
    int drive_phase = 0;
    bit word_taken = 1'b0;
    int err_count  = 0;
    int cycle_count = 0;

    spatial_focus_navigator #(
        .MAX_ELEMENTS (MAXE)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void clear_links();
        for (int s = 0; s < MAXE; s++) begin
            for (int d = 0; d < NUM_DIRS; d++) begin
                nb_ok[s][d]  = 1'b0;
                nb_idx[s][d] = 0;
            end
        end
    endfunction

    function automatic logic [DIR_W-1:0] direction_of(longint dx, longint dy);
        longint ax;
        longint ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax > ay)
            return dx > 0 ? DIR_RIGHT : DIR_LEFT;
        return dy > 0 ? DIR_DOWN : DIR_UP;
    endfunction

    function automatic longint sq_dist(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(elem_cx[b]) - longint'(elem_cx[a]);
        dy = longint'(elem_cy[b]) - longint'(elem_cy[a]);
        return dx * dx + dy * dy;
    endfunction

    // Nearest other element per direction; a strict compare keeps the earlier
    // element on a tie.
    function automatic void rebuild_links();
        logic [DIR_W-1:0] d;
        clear_links();
        for (int s = 0; s < elem_count; s++) begin
            for (int t = 0; t < elem_count; t++) begin
                if (t != s) begin
                    d = direction_of(longint'(elem_cx[t]) - longint'(elem_cx[s]),
                                     longint'(elem_cy[t]) - longint'(elem_cy[s]));
                    if (!nb_ok[s][d] || sq_dist(s, t) < sq_dist(s, nb_idx[s][d])) begin
                        nb_idx[s][d] = t;
                        nb_ok[s][d]  = 1'b1;
                    end
                end
            end
        end
    endfunction

    task automatic predict_focus(sfn_req_t req, logic [S_TDATA_W-1:0] d);
        sfn_result_t      r;
        logic [DIR_W-1:0] dir;
        r   = '0;
        dir = d[DIR_LSB +: DIR_W];
        case (req)
            REQ_CLEAR: begin
                elem_count = 0;
                clear_links();
                focus_idx = 0;
                focus_ok  = 1'b0;
            end
            REQ_APPEND: begin
                if (elem_count >= MAXE) begin
                    r.table_full = 1'b1;
                end else begin
                    elem_cx[elem_count] = 2 * int'($signed(d[0 +: POS_W]))
                                        + int'(d[W_LSB +: SIZE_W]);
                    elem_cy[elem_count] = 2 * int'($signed(d[PY_LSB +: POS_W]))
                                        + int'(d[H_LSB +: SIZE_W]);
                    elem_count++;
                end
            end
            REQ_BUILD: begin
                rebuild_links();
                focus_idx = 0;
                focus_ok  = elem_count > 0;
                r.focus_changed = elem_count > 0;
            end
            default: begin
                if (focus_ok && nb_ok[focus_idx][dir]) begin
                    focus_idx = nb_idx[focus_idx][dir];
                    r.focus_changed = 1'b1;
                end
            end
        endcase
        r.focus_valid = focus_ok;
        r.focus_index = focus_ok ? FOCUS_W'(focus_idx) : '0;
        expected_focus_q.insert(expected_focus_q.size(), r);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch_proc
        sfn_result_t got;
        sfn_result_t want;
        if (!aresetn) begin
            word_taken = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = sfn_result_t'(m_tdata);
                if (expected_focus_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result word 0x%02h with nothing expected", m_tdata);
                end else begin
                    want = expected_focus_q.pop_front();
                    compare_field("focus_index", want.focus_index, got.focus_index);
                    compare_field("focus_valid", want.focus_valid, got.focus_valid);
                    compare_field("focus_changed", want.focus_changed, got.focus_changed);
                    compare_field("table_full", want.table_full, got.table_full);
                end
            end
            word_taken = s_tvalid && s_tready;
            if (word_taken)
                predict_focus(sfn_req_t'(s_tuser), s_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Driver: request words from the pending queue, result back-pressure
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_proc
        req_word_t nxt;
        bit        go;
        if (aresetn) begin
            if (!s_tvalid || word_taken) begin
                go = 1'b0;
                if (pending_q.size() > 0) begin
                    nxt = pending_q[0];
                    // A drain word waits until every outstanding result is back.
                    if (!(nxt.drain_first && expected_focus_q.size() != 0))
                        go = $urandom_range(0, 99) >= send_idle_pct[nxt.phase];
                end
                if (go) begin
                    void'(pending_q.pop_front());
                    drive_phase = nxt.phase;
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.req;
                    s_tdata  <= {nxt.dir, nxt.h, nxt.w, nxt.py, nxt.px};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct[drive_phase];
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_word(sfn_req_t req, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                             logic [DIR_W-1:0] dir);
        req_word_t it;
        int        ph;
        ph = gen_count * 4 / NUM_ITEMS;
        if (ph > 3)
            ph = 3;
        it.req = req;
        it.px = px;
        it.py = py;
        it.w = w;
        it.h = h;
        it.dir = dir;
        it.phase = ph;
        it.drain_first = ph != gen_phase;
        gen_phase = ph;
        pending_q.insert(pending_q.size(), it);
        gen_count++;
    endtask

    task automatic push_append(int px, int py, int w, int h);
        push_word(REQ_APPEND, POS_W'(px), POS_W'(py), SIZE_W'(w), SIZE_W'(h),
                  DIR_W'($urandom_range(0, 3)));
    endtask

    // Unused fields carry random bits so that every bit toggles.
    task automatic push_other(sfn_req_t req, logic [DIR_W-1:0] dir);
        push_word(req, POS_W'($urandom_range(0, 32767)), POS_W'($urandom_range(0, 32767)),
                  SIZE_W'($urandom_range(0, 4095)), SIZE_W'($urandom_range(0, 4095)), dir);
    endtask

    // A tight grid gives ties and coincident centers; the wider modes give
    // spread-out and extreme tables.
    task automatic push_random_element(int mode);
        case (mode)
            0: push_append($urandom_range(0, 4) * 8 - 16, $urandom_range(0, 4) * 8 - 16,
                           $urandom_range(0, 1) * 16, $urandom_range(0, 1) * 16);
            1: push_append(int'($urandom_range(0, 4000)) - 2000,
                           int'($urandom_range(0, 4000)) - 2000,
                           $urandom_range(0, 300), $urandom_range(0, 300));
            default: push_append($urandom_range(0, 32767), $urandom_range(0, 32767),
                                 $urandom_range(0, 4095), $urandom_range(0, 4095));
        endcase
    endtask

    initial begin : stim_proc
        bit first_seq;
        int n;
        int mode;
        int k;

        // Directed opening.
        push_other(REQ_MOVE, DIR_UP);
        push_other(REQ_BUILD, DIR_RIGHT);
        push_append(0, 0, 100, 100);
        push_append(-16384, -16384, 0, 0);
        push_append(16383, 16383, 4095, 4095);
        push_append(0, 0, 100, 100);
        push_append(200, 0, 100, 100);
        push_append(-200, 10, 100, 100);
        push_other(REQ_BUILD, DIR_LEFT);
        push_other(REQ_MOVE, DIR_UP);
        push_other(REQ_MOVE, DIR_DOWN);
        push_other(REQ_MOVE, DIR_LEFT);
        push_other(REQ_MOVE, DIR_RIGHT);
        push_other(REQ_MOVE, DIR_LEFT);
        push_append(0, 300, 100, 100);
        push_other(REQ_MOVE, DIR_DOWN);
        push_other(REQ_BUILD, DIR_DOWN);
        push_other(REQ_MOVE, DIR_DOWN);
        push_other(REQ_CLEAR, DIR_UP);
        push_other(REQ_MOVE, DIR_RIGHT);
        push_append(5, 5, 10, 10);
        push_other(REQ_BUILD, DIR_UP);
        push_other(REQ_MOVE, DIR_LEFT);

        // Random tables; the first one overfills the table.
        first_seq = 1'b1;
        while (gen_count < NUM_ITEMS) begin
            if (!first_seq && $urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_other(sfn_req_t'($urandom_range(0, 3)), DIR_W'($urandom_range(0, 3)));
            end else begin
                if (first_seq || $urandom_range(0, 2) == 0)
                    push_other(REQ_CLEAR, DIR_W'($urandom_range(0, 3)));
                if (first_seq)
                    n = MAXE + 2;
                else if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(20, MAXE + 2);
                else
                    n = $urandom_range(1, 8);
                mode = $urandom_range(0, 2);
                repeat (n)
                    push_random_element(mode);
                push_other(REQ_BUILD, DIR_W'($urandom_range(0, 3)));
                repeat ($urandom_range(3, 12)) begin
                    k = $urandom_range(0, 19);
                    if (k == 0)
                        push_random_element(mode);
                    else if (k == 1)
                        push_other(REQ_BUILD, DIR_W'($urandom_range(0, 3)));
                    else
                        push_other(REQ_MOVE, DIR_W'($urandom_range(0, 3)));
                end
            end
            first_seq = 1'b0;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || expected_focus_q.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
